FILE: rtl/dlsfs_pkg.sv
// Shared types, constants and helpers for the dual LED strand frame serializer.
package dlsfs_pkg;

   localparam int WordBits    = 32;
   localparam int CountWidth  = $clog2(WordBits);
   localparam int HeaderBits  = 3;
   localparam int BrightBits  = 5;
   localparam int ColorBits   = 24;
   localparam int QueueDepth  = 2;

   localparam logic [BrightBits-1:0] BrightnessReset = 5'd16;
   localparam logic                  LsbFirstReset   = 1'b1;

   // Register indexes on the csr channel.
   localparam int CsrIndexWidth = 1;
   localparam logic [CsrIndexWidth-1:0] CSR_BRIGHTNESS = 1'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_LSB_FIRST  = 1'd1;
   localparam int CsrDataWidth = BrightBits;

   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_PIXEL = 2'd1,
      OP_END   = 2'd2
   } op_type;

   typedef struct packed {
      logic [1:0]           operation;
      logic [ColorBits-1:0] color_a;
      logic [ColorBits-1:0] color_b;
   } req_type;

   typedef struct packed {
      logic bit_a;
      logic bit_b;
      logic word_end;
   } rsp_type;

   // Bit k of each word is the level sent on the k-th pulse.
   typedef struct packed {
      logic [WordBits-1:0] word_a;
      logic [WordBits-1:0] word_b;
   } frame_type;

   function automatic logic [BrightBits-1:0] rev_bright(input logic [BrightBits-1:0] v);
      logic [BrightBits-1:0] r;
      for (int i = 0; i < BrightBits; i++) begin
         r[i] = v[BrightBits-1-i];
      end
      return r;
   endfunction

   function automatic logic [ColorBits-1:0] rev_color(input logic [ColorBits-1:0] v);
      logic [ColorBits-1:0] r;
      for (int i = 0; i < ColorBits; i++) begin
         r[i] = v[ColorBits-1-i];
      end
      return r;
   endfunction

endpackage

FILE: rtl/dlsfs_front.sv
// Front end: control registers, item classification and word assembly.
module dlsfs_front
   import dlsfs_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     q_full,
   input  req_type                  req_data,
   input  logic                     csr_valid,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_data,
   output logic                     csr_ready,
   output logic                     push,
   output frame_type                push_data
);

   logic [BrightBits-1:0] brightness_ff, brightness_in;
   logic                  lsb_first_ff, lsb_first_in;
   logic                  accept;
   logic [BrightBits-1:0] bright_seq;
   logic [ColorBits-1:0]  color_a_seq, color_b_seq;

   assign csr_ready = 1'b1;
   assign accept    = start && !q_full;

   always_comb begin
      brightness_in = brightness_ff;
      lsb_first_in  = lsb_first_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_BRIGHTNESS: brightness_in = csr_data;
            CSR_LSB_FIRST:  lsb_first_in  = csr_data[0];
            default:        ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         brightness_ff <= BrightnessReset;
         lsb_first_ff  <= LsbFirstReset;
      end else begin
         brightness_ff <= brightness_in;
         lsb_first_ff  <= lsb_first_in;
      end
   end

   // Put fields in send order: bit 0 goes out first.
   assign bright_seq  = lsb_first_ff ? brightness_ff    : rev_bright(brightness_ff);
   assign color_a_seq = lsb_first_ff ? req_data.color_a : rev_color(req_data.color_a);
   assign color_b_seq = lsb_first_ff ? req_data.color_b : rev_color(req_data.color_b);

   always_comb begin
      push      = 1'b0;
      push_data = '0;
      unique case (req_data.operation)
         OP_START: begin
            push = accept;
         end
         OP_PIXEL: begin
            push             = accept;
            push_data.word_a = {color_a_seq, bright_seq, {HeaderBits{1'b1}}};
            push_data.word_b = {color_b_seq, bright_seq, {HeaderBits{1'b1}}};
         end
         OP_END: begin
            push      = accept;
            push_data = '1;
         end
         default: begin
            // unused code: drop the item
            push = 1'b0;
         end
      endcase
   end

endmodule

FILE: rtl/dlsfs_queue.sv
// Short register queue between the front end and the serializer.
module dlsfs_queue
   import dlsfs_pkg::*;
#(
   parameter int Depth = QueueDepth
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  frame_type push_data,
   input  logic      pop,
   output frame_type pop_data,
   output logic      full,
   output logic      empty
);

   localparam int PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntWidth = $clog2(Depth + 1);
   localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(Depth - 1);
   localparam logic [CntWidth-1:0] FullCnt = CntWidth'(Depth);

   frame_type             slot_ff [Depth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   count_ff, count_in;
   logic                  do_push, do_pop;

   assign full     = (count_ff == FullCnt);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/dlsfs_back.sv
// Back end: shifts each queued word out one bit per strand per cycle.
module dlsfs_back
   import dlsfs_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      q_empty,
   input  frame_type q_data,
   output logic      pop,
   output logic      rsp_strobe,
   output rsp_type   rsp_data
);

   localparam logic [CountWidth-1:0] LastBit = CountWidth'(WordBits - 1);

   logic                  active_ff, active_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [WordBits-1:0]   sa_ff, sa_in;
   logic [WordBits-1:0]   sb_ff, sb_in;
   logic                  last;

   assign last = active_ff && (count_ff == LastBit);
   // Load the next word on the last bit so words run without a gap.
   assign pop  = !q_empty && (!active_ff || last);

   always_comb begin
      active_in = active_ff;
      count_in  = count_ff;
      sa_in     = sa_ff;
      sb_in     = sb_ff;
      if (pop) begin
         active_in = 1'b1;
         count_in  = '0;
         sa_in     = q_data.word_a;
         sb_in     = q_data.word_b;
      end else if (active_ff) begin
         count_in = count_ff + 1'b1;
         sa_in    = {1'b0, sa_ff[WordBits-1:1]};
         sb_in    = {1'b0, sb_ff[WordBits-1:1]};
         if (last) begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         active_ff <= active_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      sa_ff <= sa_in;
      sb_ff <= sb_in;
   end

   assign rsp_strobe        = active_ff;
   assign rsp_data.bit_a    = sa_ff[0];
   assign rsp_data.bit_b    = sb_ff[0];
   assign rsp_data.word_end = last;

endmodule

FILE: rtl/dual_led_strand_frame_serializer.sv
// Top level of the dual LED strand frame serializer.
//
// Each command word asks for one 32-bit frame word: a start frame (all zero),
// a pixel word (three header ones, 5-bit global brightness, 24-bit color per
// strand) or an end frame (all one). The block sends it as 32 result words,
// one per clock cycle, each carrying the data level for strand A and strand B
// and a word_end flag on the 32nd bit. A command is registered in the queue and
// then loaded into the back-end shift register before its first bit shows up.
// A short queue sits between the front end (control registers, word assembly)
// and the serializer, so the next command is taken while the current word is
// still shifting out, and consecutive words leave with no idle cycle between
// them. busy is high only while the queue is full. The receiver cannot stall:
// each result word is on rsp_data for exactly the cycle that rsp_strobe marks.
// Operation code 3 is dropped and gives no results. Brightness and bit order
// are taken when the command is accepted; write them through the csr port only
// while idle.
module dual_led_strand_frame_serializer
   import dlsfs_pkg::*;
#(
   parameter int QDepth = QueueDepth
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  req_type                  req_data,
   output logic                     rsp_strobe,
   output rsp_type                  rsp_data,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_data
);

   logic      q_full;
   logic      q_empty;
   logic      push;
   logic      pop;
   frame_type push_data;
   frame_type pop_data;

   // Hold off commands only when there is no room in the queue.
   assign busy = q_full;

   dlsfs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .q_full    (q_full),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .csr_ready (csr_ready),
      .push      (push),
      .push_data (push_data)
   );

   dlsfs_queue #(
      .Depth (QDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   // Advance through each queued word one bit per cycle.
   dlsfs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_data     (pop_data),
      .pop        (pop),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the dual LED strand frame serializer.
`timescale 1ns / 100ps

module tb;
   import dlsfs_pkg::*;

   localparam int          WatchdogLimit = 2000;
   localparam int          SettleCycles  = 8;
   localparam int          ReportLimit   = 10;
   localparam logic [1:0]  OpUnused      = 2'd3;
   localparam logic [23:0] ColorFull     = 24'hFFFFFF;
   localparam logic [23:0] ColorNone     = 24'h000000;

   // Predicts the serial bits of every frame word and checks them in order.
   class strand_bit_predictor;
      logic [BrightBits-1:0] brightness;
      logic                  lsb_first;
      rsp_type               expected_bits[$];
      int unsigned           failures;
      int unsigned           bits_checked;
      int unsigned           words_seen[4];

      function new();
         brightness = BrightnessReset;
         lsb_first  = LsbFirstReset;
      endfunction

      function void set_register(logic [CsrIndexWidth-1:0] index,
                                 logic [CsrDataWidth-1:0] value);
         if (index == CSR_BRIGHTNESS) begin
            brightness = value[BrightBits-1:0];
         end else if (index == CSR_LSB_FIRST) begin
            lsb_first = value[0];
         end
      endfunction

      // Bit pos of a field of the given width, in the current sending order.
      function logic pick(logic [ColorBits-1:0] value, int pos, int width);
         return lsb_first ? value[pos] : value[width - 1 - pos];
      endfunction

      function void note_command(req_type item);
         rsp_type level;
         int      p;
         words_seen[item.operation]++;
         if (item.operation != OP_START && item.operation != OP_PIXEL &&
             item.operation != OP_END) begin
            return;
         end
         for (int k = 0; k < WordBits; k++) begin
            case (item.operation)
               OP_START: begin
                  level.bit_a = 1'b0;
                  level.bit_b = 1'b0;
               end
               OP_END: begin
                  level.bit_a = 1'b1;
                  level.bit_b = 1'b1;
               end
               default: begin
                  if (k < HeaderBits) begin
                     level.bit_a = 1'b1;
                     level.bit_b = 1'b1;
                  end else if (k < HeaderBits + BrightBits) begin
                     level.bit_a = pick(ColorBits'(brightness), k - HeaderBits, BrightBits);
                     level.bit_b = level.bit_a;
                  end else begin
                     p = k - HeaderBits - BrightBits;
                     level.bit_a = pick(item.color_a, p, ColorBits);
                     level.bit_b = pick(item.color_b, p, ColorBits);
                  end
               end
            endcase
            level.word_end = (k == WordBits - 1);
            expected_bits.push_back(level);
         end
      endfunction

      function void check_bit(rsp_type got);
         rsp_type want;
         if (expected_bits.size() == 0) begin
            failures++;
            if (failures <= ReportLimit) begin
               $display("unexpected serial bit: a=%b b=%b end=%b",
                        got.bit_a, got.bit_b, got.word_end);
            end
            return;
         end
         want = expected_bits.pop_front();
         if (got.bit_a !== want.bit_a || got.bit_b !== want.bit_b ||
             got.word_end !== want.word_end) begin
            failures++;
            if (failures <= ReportLimit) begin
               $display("word %0d bit %0d: expected a=%b b=%b end=%b, got a=%b b=%b end=%b",
                        bits_checked / WordBits, bits_checked % WordBits,
                        want.bit_a, want.bit_b, want.word_end,
                        got.bit_a, got.bit_b, got.word_end);
            end
         end
         bits_checked++;
      endfunction

      function int pending();
         return expected_bits.size();
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     start;
   logic                     busy;
   req_type                  req_data;
   logic                     rsp_strobe;
   rsp_type                  rsp_data;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0]  csr_data;

   strand_bit_predictor bit_predictor;
   int unsigned         idle_cycles;
   int unsigned         settings_written;

   dual_led_strand_frame_serializer DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #10 clock = ~clock;

   // Sample both channels with the values held just before the edge. Every
   // handshake of any kind clears the watchdog; a long silence ends the run.
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles = 0;
      end else begin
         if (rsp_strobe === 1'b1) begin
            bit_predictor.check_bit(rsp_data);
         end
         if (start && !busy) begin
            bit_predictor.note_command(req_data);
         end
         if ((rsp_strobe === 1'b1) || (start && !busy) || (csr_valid && csr_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= WatchdogLimit) begin
            $display("watchdog: no handshake for %0d cycles", WatchdogLimit);
            $display("dual_led_strand_frame_serializer regression: fail");
            $finish;
         end
      end
   end

   function automatic req_type make_word(logic [1:0] op, logic [23:0] ca, logic [23:0] cb);
      req_type item;
      item.operation = op;
      item.color_a   = ca;
      item.color_b   = cb;
      return item;
   endfunction

   // Mix plain random colors with the extremes and single set bits.
   function automatic logic [23:0] random_color();
      case ($urandom_range(0, 7))
         0:       return ColorNone;
         1:       return ColorFull;
         2:       return 24'(1) << $urandom_range(0, ColorBits - 1);
         default: return 24'($urandom);
      endcase
   endfunction

   // Present one word and hold start until the block takes it.
   task automatic send_word(input req_type item);
      start    <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
   endtask

   // Drop start for a while, with junk on the data bus. Some long gaps cover a
   // whole frame word so that idle stretches land on every bit position.
   task automatic idle_sender();
      int unsigned gap;
      gap      = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      start    <= 1'b0;
      req_data <= make_word(2'($urandom), 24'($urandom), 24'($urandom));
      repeat (gap) @(posedge clock);
   endtask

   task automatic send_paced(input req_type item, input int idle_pct);
      if ($urandom_range(0, 99) < idle_pct) begin
         idle_sender();
      end
      send_word(item);
   endtask

   // Drop start and wait on the clock so the monitor has recorded the last word
   // taken, then hold off until every predicted bit is out and the block
   // has gone quiet.
   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (bit_predictor.pending() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CsrIndexWidth-1:0] index,
                            input logic [CsrDataWidth-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      bit_predictor.set_register(index, value);
   endtask

   // Waits until the block is idle, then writes both registers.
   task automatic write_settings(input logic [BrightBits-1:0] brightness, input logic lsb_first);
      settle();
      write_reg(CSR_BRIGHTNESS, CsrDataWidth'(brightness));
      write_reg(CSR_LSB_FIRST, CsrDataWidth'(lsb_first));
      csr_valid <= 1'b0;
      settings_written++;
   endtask

   // Frame-shaped traffic: start, a few pixels, end. Some frames lose their
   // start or end, and now and then an unused code sneaks in as noise.
   task automatic run_frames(input int count, input int idle_pct);
      int sent;
      int pixels;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 99) < 90) begin
            send_paced(make_word(OP_START, random_color(), random_color()), idle_pct);
            sent++;
         end
         pixels = $urandom_range(1, 6);
         repeat (pixels) begin
            if ($urandom_range(0, 99) < 8) begin
               send_paced(make_word(OpUnused, random_color(), random_color()), idle_pct);
            end
            send_paced(make_word(OP_PIXEL, random_color(), random_color()), idle_pct);
            sent++;
         end
         if ($urandom_range(0, 99) < 85) begin
            send_paced(make_word(OP_END, random_color(), random_color()), idle_pct);
            sent++;
         end
      end
   endtask

   initial begin
      bit_predictor    = new();
      settings_written = 0;
      reset     <= 1'b1;
      start     <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed words at the reset settings: colors ignored outside pixel
      // words, extreme colors per strand, and an unused code that must vanish.
      send_word(make_word(OP_START, ColorFull, ColorFull));
      send_word(make_word(OP_PIXEL, ColorNone, ColorNone));
      send_word(make_word(OP_PIXEL, ColorFull, ColorFull));
      send_word(make_word(OP_PIXEL, ColorFull, ColorNone));
      send_word(make_word(OP_PIXEL, ColorNone, ColorFull));
      send_word(make_word(OP_PIXEL, 24'h000001, 24'h800000));
      send_word(make_word(OP_PIXEL, 24'h5A3C96, 24'hA5C369));
      send_word(make_word(OpUnused, ColorFull, ColorFull));
      send_word(make_word(OP_END, 24'h123456, 24'h654321));

      // Full brightness, most significant bit first: header stays all ones.
      write_settings(5'd31, 1'b0);
      send_word(make_word(OP_START, ColorNone, ColorNone));
      send_word(make_word(OP_PIXEL, 24'h000001, 24'h800000));
      send_word(make_word(OP_PIXEL, 24'hF0F0F0, 24'h0F0F0F));
      send_word(make_word(OpUnused, 24'h123456, ColorNone));
      send_word(make_word(OP_PIXEL, ColorNone, ColorNone));
      send_word(make_word(OP_END, ColorFull, ColorFull));

      // Zero brightness in both orders.
      write_settings(5'd0, 1'b1);
      send_word(make_word(OP_PIXEL, ColorFull, ColorFull));
      send_word(make_word(OP_PIXEL, 24'h800000, 24'h000001));
      write_settings(5'd0, 1'b0);
      send_word(make_word(OP_PIXEL, 24'hAAAAAA, 24'h555555));

      // Random frames: back to back, then with the sender idling.
      write_settings(5'($urandom_range(1, 30)), 1'b1);
      run_frames(40, 0);
      write_settings(5'd31, 1'b0);
      run_frames(40, 48);
      write_settings(5'($urandom), 1'b0);
      run_frames(40, 13);
      write_settings(5'($urandom), 1'($urandom));
      run_frames(40, 48);

      settle();
      $display("covered %0d start, %0d pixel and %0d end words, %0d unused codes dropped",
               bit_predictor.words_seen[OP_START], bit_predictor.words_seen[OP_PIXEL],
               bit_predictor.words_seen[OP_END], bit_predictor.words_seen[OpUnused]);
      $display("checked %0d serial bits over %0d register settings, %0d failures",
               bit_predictor.bits_checked, settings_written, bit_predictor.failures);
      if (bit_predictor.failures == 0 && bit_predictor.pending() == 0) begin
         $display("dual_led_strand_frame_serializer regression: pass");
      end else begin
         $display("dual_led_strand_frame_serializer regression: fail");
      end
      $finish;
   end

endmodule
